/* rtl/motor_safe_arming_interlock_assert.svh */
// ----------------------------------------------------------------------------
// motor_safe_arming_interlock_assert.svh
// assertion macros shared by the arming interlock rtl
// ----------------------------------------------------------------------------
`ifndef MOTOR_SAFE_ARMING_INTERLOCK_ASSERT_SVH
`define MOTOR_SAFE_ARMING_INTERLOCK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSAI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MSAI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/msai_pkg.sv */
// ----------------------------------------------------------------------------
// msai_pkg
// shared types and constants of the motor arming interlock
// ----------------------------------------------------------------------------
`default_nettype none

package msai_pkg;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_WATCHDOG = 2'd0;
    localparam logic [1:0] REG_MAX_TEMP = 2'd1;
    localparam logic [1:0] REG_ARM_WAIT = 2'd2;
    localparam logic [1:0] REG_PWM_PER  = 2'd3;

    // reset values of the configuration registers
    localparam logic [15:0] WATCHDOG_RESET = 16'd500;
    localparam logic [7:0]  MAX_TEMP_RESET = 8'd120;
    localparam logic [15:0] ARM_WAIT_RESET = 16'd2000;
    localparam logic [15:0] PWM_PER_RESET  = 16'd20000;

    // full-scale throttle byte and the product width throttle * period
    localparam int THROTTLE_FULL = 255;
    localparam int PRODUCT_BITS  = 24;

    typedef struct packed {
        logic [15:0] watchdog_timeout_ms;
        logic [7:0]  temp_limit;
        logic [15:0] arm_wait_ms;
        logic [15:0] pwm_period_ticks;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/motor_safe_arming_interlock.sv */
// ----------------------------------------------------------------------------
// motor_safe_arming_interlock
// fault detection and safe-start arming of a pwm motor drive
// ----------------------------------------------------------------------------
// One transaction per control tick: a millisecond timestamp plus the throttle
// and temperature frames. A zero-length throttle frame, a temperature above
// the temperature limit in a non-empty frame, or a gap longer than
// watchdog_timeout_ms since the last valid throttle frame raises a fault and
// disarms the motor. While disarmed the compare is 0; arming needs zero
// throttle held fault-free for arm_wait_ms, and the arming tick itself still
// drives 0. While armed the compare is throttle * pwm_period_ticks / 255.
// Timestamps wrap modulo 2^TIMESTAMP_BITS. The block takes a transaction
// every cycle unless in_stall holds it off, and returns one result per
// transaction through three register stages: input register, state update
// and product, then the divide by 255 into the output register.
// Configuration must be written over apb only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_safe_arming_interlock #(
    parameter int TIMESTAMP_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [31:0]                     now_ms,
    input  wire logic [3:0]                      throttle_length,
    input  wire logic [7:0]                      throttle_value,
    input  wire logic [3:0]                      temp_length,
    input  wire logic [7:0]                      temp_value,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [15:0]                     compare_value,
    output logic                                 armed,
    output logic                                 length_fault,
    output logic                                 over_temp,
    output logic                                 link_timeout,
    output logic                                 fault_active,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [msai_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [msai_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [msai_pkg::DATA_BITS-1:0]  prdata,
    output logic                                 pready
);
    import msai_pkg::*;

    localparam int TS = TIMESTAMP_BITS;

    typedef struct packed {
        logic length_fault;
        logic over_temp;
        logic link_timeout;
    } flags_t;

    cfg_t cfg;

    msai_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when the one after it can
    // take its contents
    // ------------------------------------------------------------------
    logic i_valid_reg;
    logic m_valid_reg;
    logic out_valid_reg;
    logic adv_out;
    logic adv_mid;
    logic accept_in;
    logic step;

    assign adv_out   = !out_valid_reg || !out_stall;
    assign adv_mid   = !m_valid_reg || adv_out;
    assign in_stall  = i_valid_reg && !adv_mid;
    assign accept_in = in_valid && !in_stall;
    assign step      = i_valid_reg && adv_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                i_valid_reg <= in_valid;
            if (adv_mid)
                m_valid_reg <= i_valid_reg;
            if (adv_out)
                out_valid_reg <= m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic [31:0] i_now_reg;
    logic [3:0]  i_tlen_reg;
    logic [7:0]  i_tval_reg;
    logic [3:0]  i_plen_reg;
    logic [7:0]  i_pval_reg;

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            i_now_reg  <= now_ms;
            i_tlen_reg <= throttle_length;
            i_tval_reg <= throttle_value;
            i_plen_reg <= temp_length;
            i_pval_reg <= temp_value;
        end
    end

    // ------------------------------------------------------------------
    // interlock state and fault evaluation
    // ------------------------------------------------------------------
    logic          operating_reg,  operating_next;
    logic          waiting_reg,    waiting_next;
    logic [TS-1:0] zero_start_reg, zero_start_next;
    logic [TS-1:0] last_valid_reg, last_valid_next;

    logic [TS+31:0]          now_wide;
    logic [TS-1:0]           now_ts;
    logic [TS-1:0]           since_valid;
    logic [TS-1:0]           since_zero;
    logic [7:0]              throttle;
    logic                    run_kept;
    logic                    any_fault;
    flags_t                  flags;
    logic [PRODUCT_BITS-1:0] product;

    // timestamp truncated or zero-extended to the wrap width
    assign now_wide = {{TS{1'b0}}, i_now_reg};
    assign now_ts   = now_wide[TS-1:0];

    always_comb
    begin
        flags.length_fault = (i_tlen_reg == 4'd0);
        flags.over_temp    = (i_plen_reg != 4'd0) && (i_pval_reg > cfg.temp_limit);
        throttle           = flags.length_fault ? 8'd0 : i_tval_reg;

        // a valid frame refreshes the watchdog, so only a faulty one can time out
        since_valid        = now_ts - last_valid_reg;
        flags.link_timeout = flags.length_fault
                          && (since_valid > TS'(cfg.watchdog_timeout_ms));
        last_valid_next    = flags.length_fault ? last_valid_reg : now_ts;

        any_fault = flags.length_fault || flags.over_temp || flags.link_timeout;
        run_kept  = operating_reg && !any_fault;

        operating_next  = run_kept;
        waiting_next    = waiting_reg;
        zero_start_next = zero_start_reg;
        since_zero      = now_ts - zero_start_reg;

        if (!run_kept)
        begin
            if (!any_fault && (throttle == 8'd0))
            begin
                if (!waiting_reg)
                begin
                    zero_start_next = now_ts;
                    waiting_next    = 1'b1;
                end
                else if (since_zero >= TS'(cfg.arm_wait_ms))
                begin
                    operating_next = 1'b1;
                    waiting_next   = 1'b0;
                end
            end
            else
            begin
                waiting_next = 1'b0;
            end
        end

        // the arming tick itself still drives zero
        if (run_kept)
            product = {16'd0, throttle} * {8'd0, cfg.pwm_period_ticks};
        else
            product = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operating_reg  <= 1'b0;
            waiting_reg    <= 1'b0;
            zero_start_reg <= '0;
            last_valid_reg <= '0;
        end
        else if (step)
        begin
            operating_reg  <= operating_next;
            waiting_reg    <= waiting_next;
            zero_start_reg <= zero_start_next;
            last_valid_reg <= last_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // middle register: product and status of the transaction
    // ------------------------------------------------------------------
    logic [PRODUCT_BITS-1:0] m_product_reg;
    logic                    m_armed_reg;
    flags_t                  m_flags_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_product_reg <= product;
            m_armed_reg   <= operating_next;
            m_flags_reg   <= flags;
        end
    end

    // ------------------------------------------------------------------
    // scaling to the pwm period and output register
    // ------------------------------------------------------------------
    logic [15:0] scaled_compare;
    logic [15:0] o_compare_reg;
    logic        o_armed_reg;
    flags_t      o_flags_reg;

    msai_div255 u_div (
        .dividend (m_product_reg),
        .quotient (scaled_compare)
    );

    always_ff @(posedge clk)
    begin
        if (adv_out && m_valid_reg)
        begin
            o_compare_reg <= scaled_compare;
            o_armed_reg   <= m_armed_reg;
            o_flags_reg   <= m_flags_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = o_compare_reg;
    assign armed         = o_armed_reg;
    assign length_fault  = o_flags_reg.length_fault;
    assign over_temp     = o_flags_reg.over_temp;
    assign link_timeout  = o_flags_reg.link_timeout;
    assign fault_active  = o_flags_reg.length_fault || o_flags_reg.over_temp
                        || o_flags_reg.link_timeout;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `include "motor_safe_arming_interlock_assert.svh"

    // a motor left armed after a tick cannot have seen a fault on it
    `MSAI_ASSERT_IMP(a_armed_fault_free, out_valid && armed, !fault_active, "armed with fault")
    // drive only reaches the motor while armed
    `MSAI_ASSERT_IMP(a_compare_needs_arm, out_valid && (compare_value != 16'd0), armed, "drive while disarmed")
    // the zero-throttle wait only runs while disarmed
    `MSAI_ASSERT_IMP(a_wait_disarmed, waiting_reg, !operating_reg, "waiting while operating")
    // an accepted transaction lands in the input register
    `MSAI_ASSERT_NXT(a_accept_loads, accept_in, i_valid_reg, "accepted transaction lost")

endmodule

`default_nettype wire

/* rtl/msai_apb_regs.sv */
// ----------------------------------------------------------------------------
// msai_apb_regs
// apb configuration registers of the arming interlock
// ----------------------------------------------------------------------------
`default_nettype none

module msai_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [msai_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [msai_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [msai_pkg::DATA_BITS-1:0]  prdata,
    output logic                                 pready,
    output msai_pkg::cfg_t                       cfg
);
    import msai_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watchdog_timeout_ms <= WATCHDOG_RESET;
            cfg_reg.temp_limit          <= MAX_TEMP_RESET;
            cfg_reg.arm_wait_ms         <= ARM_WAIT_RESET;
            cfg_reg.pwm_period_ticks    <= PWM_PER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WATCHDOG: cfg_reg.watchdog_timeout_ms <= pwdata[15:0];
                REG_MAX_TEMP: cfg_reg.temp_limit          <= pwdata[7:0];
                REG_ARM_WAIT: cfg_reg.arm_wait_ms         <= pwdata[15:0];
                REG_PWM_PER:  cfg_reg.pwm_period_ticks    <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WATCHDOG: prdata = {16'd0, cfg_reg.watchdog_timeout_ms};
            REG_MAX_TEMP: prdata = {24'd0, cfg_reg.temp_limit};
            REG_ARM_WAIT: prdata = {16'd0, cfg_reg.arm_wait_ms};
            REG_PWM_PER:  prdata = {16'd0, cfg_reg.pwm_period_ticks};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/msai_div255.sv */
// ----------------------------------------------------------------------------
// msai_div255
// unsigned divide of the throttle-period product by full-scale throttle
// ----------------------------------------------------------------------------
`default_nettype none

module msai_div255 (
    input  wire logic [msai_pkg::PRODUCT_BITS-1:0] dividend,
    output logic      [15:0]                       quotient
);
    import msai_pkg::*;

    // reciprocal 2^24/255 rounded down is 0x10101, so the estimate is low by
    // at most one and a single compare fixes it
    logic [PRODUCT_BITS+16:0] scaled;
    logic [16:0]              q_est;
    logic [PRODUCT_BITS+1:0]  rem;
    logic [16:0]              q_fix;

    always_comb
    begin
        scaled = {17'd0, dividend}
               + ({17'd0, dividend} << 8)
               + ({17'd0, dividend} << 16);
        q_est  = scaled[PRODUCT_BITS+16:PRODUCT_BITS];
        rem    = {2'b00, dividend} + {9'd0, q_est} - ({9'd0, q_est} << 8);
        if (rem >= (PRODUCT_BITS+2)'(THROTTLE_FULL))
            q_fix = q_est + 17'd1;
        else
            q_fix = q_est;
        quotient = q_fix[15:0];
    end

endmodule

`default_nettype wire

/* verif/tb_motor_safe_arming_interlock.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_safe_arming_interlock
// self-checking bench for the motor arming interlock
// ----------------------------------------------------------------------------
// Control ticks go in over the valid/stall input channel and the pwm results
// are checked against a cycle-free model of the interlock kept in a small
// scoreboard. A short directed run walks through arming, the arming tick,
// the temperature limit, empty frames, the watchdog and timestamp wrap. The
// random part then runs mostly well-formed zero-throttle runs so that the
// motor arms often, mixed with faults and large time jumps, under several
// register settings and idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_motor_safe_arming_interlock;

    import msai_pkg::*;

    // one control tick as offered on the input channel
    typedef struct {
        logic [31:0] now_ms;
        logic [3:0]  throttle_length;
        logic [7:0]  throttle_value;
        logic [3:0]  temp_length;
        logic [7:0]  temp_value;
    } tick_t;

    // one drive result as returned on the output channel
    typedef struct {
        logic [15:0] compare_value;
        logic        armed;
        logic        length_fault;
        logic        over_temp;
        logic        link_timeout;
        logic        fault_active;
    } drive_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the arming state and holds the expected drives
    // ------------------------------------------------------------------------
    class interlock_scoreboard;
        cfg_t        cfg;
        bit          operating;
        bit          waiting_zero;
        logic [31:0] zero_start_ms;
        logic [31:0] last_valid_ms;
        drive_t      expected_drives[$];
        int          errors;
        int          ticks_noted;
        int          armed_seen;
        int          faults_seen;

        function new();
            cfg.watchdog_timeout_ms = WATCHDOG_RESET;
            cfg.temp_limit          = MAX_TEMP_RESET;
            cfg.arm_wait_ms         = ARM_WAIT_RESET;
            cfg.pwm_period_ticks    = PWM_PER_RESET;
            operating     = 1'b0;
            waiting_zero  = 1'b0;
            zero_start_ms = '0;
            last_valid_ms = '0;
            errors        = 0;
            ticks_noted   = 0;
            armed_seen    = 0;
            faults_seen   = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WATCHDOG: cfg.watchdog_timeout_ms = value[15:0];
                REG_MAX_TEMP: cfg.temp_limit          = value[7:0];
                REG_ARM_WAIT: cfg.arm_wait_ms         = value[15:0];
                REG_PWM_PER:  cfg.pwm_period_ticks    = value[15:0];
                default: ;
            endcase
        endfunction

        // advance the interlock by one accepted tick and queue its drive
        function void note_tick(tick_t t);
            drive_t      d;
            logic [7:0]  throttle;
            logic [31:0] since_valid;
            logic [31:0] since_zero;
            logic [23:0] product;
            d = '{default: '0};
            d.length_fault = (t.throttle_length == 4'd0);
            throttle = d.length_fault ? 8'd0 : t.throttle_value;
            d.over_temp = (t.temp_length != 4'd0) && (t.temp_value > cfg.temp_limit);
            if (!d.length_fault)
                last_valid_ms = t.now_ms;
            since_valid = t.now_ms - last_valid_ms;
            d.link_timeout = since_valid > {16'd0, cfg.watchdog_timeout_ms};
            d.fault_active = d.length_fault || d.over_temp || d.link_timeout;
            if (d.fault_active)
                operating = 1'b0;
            if (!operating)
            begin
                if (!d.fault_active && throttle == 8'd0)
                begin
                    if (!waiting_zero)
                    begin
                        zero_start_ms = t.now_ms;
                        waiting_zero  = 1'b1;
                    end
                    else
                    begin
                        since_zero = t.now_ms - zero_start_ms;
                        if (since_zero >= {16'd0, cfg.arm_wait_ms})
                        begin
                            operating    = 1'b1;
                            waiting_zero = 1'b0;
                        end
                    end
                end
                else
                    waiting_zero = 1'b0;
            end
            else
            begin
                product = throttle * cfg.pwm_period_ticks;
                d.compare_value = 16'(product / 24'(THROTTLE_FULL));
            end
            d.armed = operating;
            expected_drives.push_back(d);
            ticks_noted++;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (expected_drives.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            want = expected_drives.pop_front();
            check_field("compare_value", want.compare_value, got.compare_value);
            check_field("armed", want.armed, got.armed);
            check_field("length_fault", want.length_fault, got.length_fault);
            check_field("over_temp", want.over_temp, got.over_temp);
            check_field("link_timeout", want.link_timeout, got.link_timeout);
            check_field("fault_active", want.fault_active, got.fault_active);
            if (got.armed)
                armed_seen++;
            if (got.fault_active)
                faults_seen++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [31:0]          now_ms;
    logic [3:0]           throttle_length;
    logic [7:0]           throttle_value;
    logic [3:0]           temp_length;
    logic [7:0]           temp_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [15:0]          compare_value;
    logic                 armed;
    logic                 length_fault;
    logic                 over_temp;
    logic                 link_timeout;
    logic                 fault_active;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    interlock_scoreboard board;

    // idling controls, shared between the stimulus and the receiver process
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;
    // random tick generator state: running clock and remaining zero-throttle run
    logic [31:0] clock_ms;
    int          zero_run;
    int          settings_used;

    motor_safe_arming_interlock u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .throttle_length (throttle_length),
        .throttle_value  (throttle_value),
        .temp_length     (temp_length),
        .temp_value      (temp_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .compare_value   (compare_value),
        .armed           (armed),
        .length_fault    (length_fault),
        .over_temp       (over_temp),
        .link_timeout    (link_timeout),
        .fault_active    (fault_active),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // overall limit: several times the slowest legal run
    initial
    begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stall plus an optional long hold-off counted here
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result monitor: every accepted result goes to the scoreboard
    initial
    begin
        drive_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.compare_value = compare_value;
                got.armed         = armed;
                got.length_fault  = length_fault;
                got.over_temp     = over_temp;
                got.link_timeout  = link_timeout;
                got.fault_active  = fault_active;
                board.check_drive(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic tick_t make_tick(logic [31:0] t_ms, logic [3:0] tlen,
                                        logic [7:0] tval, logic [3:0] plen,
                                        logic [7:0] pval);
        tick_t t;
        t.now_ms          = t_ms;
        t.throttle_length = tlen;
        t.throttle_value  = tval;
        t.temp_length     = plen;
        t.temp_value      = pval;
        return t;
    endfunction

    // offer one tick, with random idle cycles ahead of it, until accepted
    task automatic send_tick(tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        now_ms          <= t.now_ms;
        throttle_length <= t.throttle_length;
        throttle_value  <= t.throttle_value;
        temp_length     <= t.temp_length;
        temp_value      <= t.temp_value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_tick(t);
    endtask

    // apb write: setup cycle, then access cycle, register written at its end
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers only change once every outstanding result is back
    task automatic write_settings(int unsigned wdog, int unsigned temp,
                                  int unsigned wait_ms, int unsigned period);
        while (board.expected_drives.size() != 0)
            @(posedge clk);
        apb_write(REG_WATCHDOG, wdog);
        apb_write(REG_MAX_TEMP, temp);
        apb_write(REG_ARM_WAIT, wait_ms);
        apb_write(REG_PWM_PER, period);
        settings_used++;
    endtask

    // mostly small time steps and zero-throttle runs so that arming happens,
    // with occasional faults, big jumps and random restarts of the clock
    function automatic tick_t next_random_tick();
        tick_t t;
        int    pick;
        bit    quiet;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms = clock_ms + $urandom_range(0, 20);
        else if (pick < 90)
            clock_ms = clock_ms + $urandom_range(21, 400);
        else if (pick < 97)
            clock_ms = clock_ms + $urandom_range(401, 70000);
        else
            clock_ms = $urandom;
        t.now_ms = clock_ms;
        if (zero_run == 0 && $urandom_range(0, 99) < 12)
            zero_run = $urandom_range(3, 20);
        quiet = (zero_run != 0);
        pick = $urandom_range(0, 99);
        if (pick < (quiet ? 2 : 8))
            t.throttle_length = 4'd0;
        else if (pick < 15)
            t.throttle_length = 4'($urandom_range(9, 15));
        else
            t.throttle_length = 4'($urandom_range(1, 8));
        if (quiet)
        begin
            t.throttle_value = 8'd0;
            zero_run--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            t.throttle_value = (pick < 10) ? 8'd0 : (pick < 20) ? 8'hff : 8'($urandom);
        end
        t.temp_length = ($urandom_range(0, 99) < 10) ? 4'd0 : 4'($urandom_range(1, 15));
        if ($urandom_range(0, 99) < (quiet ? 97 : 80))
            t.temp_value = 8'($urandom_range(0, board.cfg.temp_limit));
        else
            t.temp_value = 8'($urandom);
        return t;
    endfunction

    task automatic run_phase(int n, int send_pct, int stall, int hold);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        hold_cycles   = hold;
        clock_ms      = $urandom;
        zero_run      = 0;
        repeat (n)
            send_tick(next_random_tick());
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        board           = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        now_ms          = '0;
        throttle_length = '0;
        throttle_value  = '0;
        temp_length     = '0;
        temp_value      = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_cycles     = 0;
        clock_ms        = '0;
        zero_run        = 0;
        settings_used   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under the reset settings
        // empty temperature frame with a hot byte is no fault; zero throttle starts the wait
        send_tick(make_tick(32'd0, 4'd1, 8'd0, 4'd0, 8'd255));
        // temperature exactly at the limit, still waiting
        send_tick(make_tick(32'd1000, 4'd8, 8'd0, 4'd8, 8'd120));
        // arming tick: armed reads 1 but the compare stays 0
        send_tick(make_tick(32'd2000, 4'd15, 8'd0, 4'd15, 8'd0));
        // full-scale throttle, then a long throttle frame with a mid byte
        send_tick(make_tick(32'd2001, 4'd8, 8'd255, 4'd1, 8'd0));
        send_tick(make_tick(32'd2002, 4'd9, 8'd128, 4'd0, 8'd0));
        // one above the temperature limit disarms
        send_tick(make_tick(32'd2003, 4'd1, 8'd1, 4'd8, 8'd121));
        // empty throttle frames: just inside, then just past the watchdog
        send_tick(make_tick(32'd2500, 4'd0, 8'd255, 4'd0, 8'd0));
        send_tick(make_tick(32'd2504, 4'd0, 8'd0, 4'd0, 8'd0));
        // zero-throttle wait across the timestamp wrap, arming after it
        send_tick(make_tick(32'hffff_ff00, 4'd1, 8'd0, 4'd0, 8'd0));
        send_tick(make_tick(32'h0000_0700, 4'd3, 8'd0, 4'd2, 8'd100));
        send_tick(make_tick(32'h0000_0701, 4'd5, 8'd200, 4'd3, 8'd0));
        // time going backwards looks like a huge gap to the watchdog
        send_tick(make_tick(32'h0000_0100, 4'd0, 8'd0, 4'd0, 8'd0));
        send_tick(make_tick(32'haaaa_5555, 4'd10, 8'h55, 4'd5, 8'haa));
        send_tick(make_tick(32'h5555_aaaa, 4'd6, 8'haa, 4'd10, 8'h55));
        @(negedge clk);
        in_valid <= 1'b0;

        // random part: settings and idling change from phase to phase
        write_settings(100, 120, 30, 20000);
        // no idling, with a long receiver hold-off so the pipeline backs up
        run_phase(80, 0, 0, 60);
        // lowest settings: any gap times out, zero limit, zero arming wait
        write_settings(0, 0, 0, 1);
        run_phase(80, 77, 0, 0);
        write_settings(65535, 255, 65535, 65535);
        run_phase(80, 0, 77, 0);
        // zero period: armed compare must stay 0
        write_settings(20, 200, 10, 0);
        run_phase(80, 17, 17, 0);
        write_settings(300, 150, 5, 12345);
        run_phase(80, 0, 0, 0);

        // drain, then let the pipeline run on before the final check
        waited = 0;
        while (board.expected_drives.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (board.expected_drives.size() != 0)
        begin
            $error("%0d transactions never produced a result", board.expected_drives.size());
            board.errors += board.expected_drives.size();
        end

        $display("covered %0d control ticks over %0d register settings plus reset values",
                 board.ticks_noted, settings_used);
        $display("results armed: %0d, results with a fault: %0d",
                 board.armed_seen, board.faults_seen);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/msai_pkg.sv
rtl/msai_apb_regs.sv
rtl/msai_div255.sv
rtl/motor_safe_arming_interlock.sv
verif/tb_motor_safe_arming_interlock.sv
